@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file ptls_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a holds at an edge, so b holds at the same edge
`define ASSERT_IMPLY(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// a holds at an edge, so b holds at the next edge
`define ASSERT_NEXT(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

@@ rtl/ptls_pkg.sv @@
// Types and constants of the pedestrian traffic light sequencer.
// No dependencies.
package ptls_pkg;

   localparam int COUNT_WIDTH = 8;
   localparam int CFG_W       = 8;
   localparam int LEN_W       = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
   localparam int ADDR_W      = 4;
   localparam int DATA_W      = 32;

   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic [CFG_W-1:0]       LEN_RESET = CFG_W'(10);

   // lamp bit positions
   localparam logic [5:0] L_CG = 6'b000001;
   localparam logic [5:0] L_CY = 6'b000010;
   localparam logic [5:0] L_CR = 6'b000100;
   localparam logic [5:0] L_WG = 6'b001000;
   localparam logic [5:0] L_WY = 6'b010000;
   localparam logic [5:0] L_WR = 6'b100000;

   typedef enum logic [2:0] {
      PH_GREEN = 3'd0,
      PH_YEL_G = 3'd1,
      PH_RED   = 3'd2,
      PH_YEL_R = 3'd3,
      PH_ALERT = 3'd4,
      PH_WALK  = 3'd5,
      PH_CLEAR = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      REG_GREEN = 2'd0,
      REG_RED   = 2'd1,
      REG_WALK  = 2'd2,
      REG_BLINK = 2'd3
   } reg_idx_type;

   typedef struct packed {
      logic tick;
      logic request;
   } req_type;

   typedef struct packed {
      logic       car_green;
      logic       car_yellow;
      logic       car_red;
      logic       walk_green;
      logic       walk_yellow;
      logic       walk_red;
      logic [2:0] phase_code;
   } rsp_type;

   typedef struct packed {
      logic advance;
      logic tick;
      logic request;
   } ctrl_type;

   typedef struct packed {
      logic [CFG_W-1:0] green;
      logic [CFG_W-1:0] red;
      logic [CFG_W-1:0] walk;
      logic [CFG_W-1:0] blink;
   } len_type;

endpackage

@@ rtl/ptls_core.sv @@
// Phase sequencer: phase, tick count, request latch and lamp state.
// Depends on ptls_pkg.
module ptls_core (
   input  logic              clock,
   input  logic              reset,
   input  ptls_pkg::ctrl_type ctrl,
   input  ptls_pkg::len_type  lens,
   output ptls_pkg::rsp_type  result
);

   ptls_pkg::phase_type              phase_ff, phase_in;
   logic [ptls_pkg::COUNT_WIDTH-1:0] ticks_ff, ticks_in, ticks_inc;
   logic                             latch_ff, latch_in, latch_now;
   logic [5:0]                       lamps_ff, lamps_in;
   logic [ptls_pkg::CFG_W-1:0]       len;
   logic                             done, finish;

   always_comb begin
      case (phase_ff)
         ptls_pkg::PH_GREEN: len = lens.green;
         ptls_pkg::PH_RED:   len = lens.red;
         ptls_pkg::PH_WALK:  len = lens.walk;
         default:            len = lens.blink;
      endcase
   end

   assign ticks_inc = (ticks_ff == ptls_pkg::CNT_MAX) ? ticks_ff
                                                       : ticks_ff + 1'b1;
   // count is at least one after increment, so a zero length acts as one
   assign done = (ptls_pkg::LEN_W'(ticks_inc) >= ptls_pkg::LEN_W'(len)) ||
                 (ticks_inc == ptls_pkg::CNT_MAX);
   assign latch_now = latch_ff | (ctrl.request && phase_ff != ptls_pkg::PH_WALK &&
                                  phase_ff != ptls_pkg::PH_CLEAR);

   // next state
   always_comb begin
      phase_in = phase_ff;
      ticks_in = ticks_ff;
      latch_in = latch_ff;
      finish   = 1'b0;
      if (ctrl.advance) begin
         latch_in = latch_now;
         if (ctrl.tick) begin
            ticks_in = ticks_inc;
            if (done) begin
               finish   = 1'b1;
               ticks_in = '0;
               case (phase_ff)
                  ptls_pkg::PH_GREEN:
                     phase_in = latch_now ? ptls_pkg::PH_ALERT : ptls_pkg::PH_YEL_G;
                  ptls_pkg::PH_YEL_G:
                     phase_in = latch_now ? ptls_pkg::PH_ALERT : ptls_pkg::PH_RED;
                  ptls_pkg::PH_YEL_R:
                     phase_in = latch_now ? ptls_pkg::PH_ALERT : ptls_pkg::PH_GREEN;
                  ptls_pkg::PH_RED:
                     phase_in = latch_now ? ptls_pkg::PH_WALK : ptls_pkg::PH_YEL_R;
                  ptls_pkg::PH_ALERT: phase_in = ptls_pkg::PH_WALK;
                  ptls_pkg::PH_WALK:  phase_in = ptls_pkg::PH_CLEAR;
                  ptls_pkg::PH_CLEAR: begin
                     phase_in = ptls_pkg::PH_GREEN;
                     latch_in = 1'b0;
                  end
                  default: phase_in = ptls_pkg::PH_GREEN;
               endcase
            end
         end
      end
   end

   // lamps: exit then entry action on a phase change, else blink toggle
   always_comb begin
      lamps_in = lamps_ff;
      if (ctrl.advance && ctrl.tick) begin
         if (finish) begin
            case (phase_ff)
               ptls_pkg::PH_YEL_G, ptls_pkg::PH_YEL_R:
                  lamps_in = lamps_in & ~(ptls_pkg::L_CY | ptls_pkg::L_WY);
               ptls_pkg::PH_ALERT:
                  lamps_in = (lamps_in & ~(ptls_pkg::L_CY | ptls_pkg::L_WY)) | ptls_pkg::L_CR;
               ptls_pkg::PH_WALK:
                  lamps_in = lamps_in & ~ptls_pkg::L_CR;
               ptls_pkg::PH_CLEAR:
                  lamps_in = (lamps_in & ~(ptls_pkg::L_CY | ptls_pkg::L_WY)) | ptls_pkg::L_WR;
               default: lamps_in = lamps_in;
            endcase
            case (phase_in)
               ptls_pkg::PH_GREEN:
                  lamps_in = (lamps_in & ~(ptls_pkg::L_WG | ptls_pkg::L_WY |
                              ptls_pkg::L_CY | ptls_pkg::L_CR)) | ptls_pkg::L_CG;
               ptls_pkg::PH_YEL_G, ptls_pkg::PH_YEL_R:
                  lamps_in = (lamps_in & ~(ptls_pkg::L_WG | ptls_pkg::L_WY)) ^ ptls_pkg::L_CY;
               ptls_pkg::PH_RED:
                  lamps_in = (lamps_in & ~(ptls_pkg::L_WG | ptls_pkg::L_WY |
                              ptls_pkg::L_CG | ptls_pkg::L_CY)) | ptls_pkg::L_CR;
               ptls_pkg::PH_ALERT:
                  lamps_in = ((lamps_in & ~(ptls_pkg::L_WG | ptls_pkg::L_WY)) |
                              ptls_pkg::L_WR) ^ (ptls_pkg::L_CY | ptls_pkg::L_WY);
               ptls_pkg::PH_WALK:
                  lamps_in = ptls_pkg::L_WG | ptls_pkg::L_CR;
               default:
                  lamps_in = lamps_in ^ (ptls_pkg::L_CY | ptls_pkg::L_WY);
            endcase
         end else begin
            case (phase_ff)
               ptls_pkg::PH_YEL_G, ptls_pkg::PH_YEL_R:
                  lamps_in = lamps_in ^ ptls_pkg::L_CY;
               ptls_pkg::PH_ALERT, ptls_pkg::PH_CLEAR:
                  lamps_in = lamps_in ^ (ptls_pkg::L_CY | ptls_pkg::L_WY);
               default: lamps_in = lamps_in;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ptls_pkg::PH_GREEN;
         ticks_ff <= '0;
         latch_ff <= 1'b0;
         lamps_ff <= ptls_pkg::L_CG;
      end else begin
         phase_ff <= phase_in;
         ticks_ff <= ticks_in;
         latch_ff <= latch_in;
         lamps_ff <= lamps_in;
      end
   end

   assign result.car_green   = lamps_in[0];
   assign result.car_yellow  = lamps_in[1];
   assign result.car_red     = lamps_in[2];
   assign result.walk_green  = lamps_in[3];
   assign result.walk_yellow = lamps_in[4];
   assign result.walk_red    = lamps_in[5];
   assign result.phase_code  = phase_in;

endmodule

@@ rtl/pedestrian_traffic_light_sequencer.sv @@
// A word accepted at one edge shows on rsp_data from the next cycle.
// Throughput: one word per cycle while rsp_ready is high; the result register frees as it is taken.
// Reset (synchronous): green just entered, only car green lit, latch clear,
// all lengths 10 ticks, no result pending.
// Depends on ptls_pkg and ptls_core.
module pedestrian_traffic_light_sequencer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  ptls_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output ptls_pkg::rsp_type             rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [ptls_pkg::ADDR_W-1:0]   paddr,
   input  logic [ptls_pkg::DATA_W-1:0]   pwdata,
   output logic [ptls_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);

   ptls_pkg::len_type  lens_ff, lens_in;
   ptls_pkg::ctrl_type ctrl;
   ptls_pkg::rsp_type  result, rsp_data_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               accept, wr_en;
   ptls_pkg::reg_idx_type idx;

   assign pready    = 1'b1;
   assign idx       = ptls_pkg::reg_idx_type'(paddr[3:2]);
   assign wr_en     = psel && penable && pwrite && pready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      lens_in = lens_ff;
      if (wr_en) begin
         case (idx)
            ptls_pkg::REG_GREEN: lens_in.green = pwdata[ptls_pkg::CFG_W-1:0];
            ptls_pkg::REG_RED:   lens_in.red   = pwdata[ptls_pkg::CFG_W-1:0];
            ptls_pkg::REG_WALK:  lens_in.walk  = pwdata[ptls_pkg::CFG_W-1:0];
            ptls_pkg::REG_BLINK: lens_in.blink = pwdata[ptls_pkg::CFG_W-1:0];
            default:             lens_in = lens_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         ptls_pkg::REG_GREEN: prdata = ptls_pkg::DATA_W'(lens_ff.green);
         ptls_pkg::REG_RED:   prdata = ptls_pkg::DATA_W'(lens_ff.red);
         ptls_pkg::REG_WALK:  prdata = ptls_pkg::DATA_W'(lens_ff.walk);
         ptls_pkg::REG_BLINK: prdata = ptls_pkg::DATA_W'(lens_ff.blink);
         default:             prdata = '0;
      endcase
   end

   assign ctrl.advance = accept;
   assign ctrl.tick    = req_data.tick;
   assign ctrl.request = req_data.request;

   ptls_core u_core (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .lens   (lens_ff),
      .result (result)
   );

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         lens_ff      <= {4{ptls_pkg::LEN_RESET}};
         rsp_valid_ff <= 1'b0;
      end else begin
         lens_ff      <= lens_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/ptls_checker.sv @@
// Port-level checks on the sequencer, bound to the top level.
// Depends on ptls_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ptls_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input ptls_pkg::rsp_type rsp_data
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result word dropped or changed while stalled")
   `ASSERT_IMPLY(a_ready_free, clock, reset, !rsp_valid, req_ready, "input stalled with result register empty")
   `ASSERT_IMPLY(a_phase_range, clock, reset, rsp_valid, rsp_data.phase_code <= ptls_pkg::PH_CLEAR, "phase code out of range")
   `ASSERT_IMPLY(a_walk_lamps, clock, reset, rsp_valid && rsp_data.phase_code == ptls_pkg::PH_WALK, rsp_data.walk_green && rsp_data.car_red && !rsp_data.car_green && !rsp_data.car_yellow && !rsp_data.walk_yellow && !rsp_data.walk_red, "wrong lamps in walk")
   `ASSERT_IMPLY(a_green_lamps, clock, reset, rsp_valid && rsp_data.phase_code == ptls_pkg::PH_GREEN, rsp_data.car_green && !rsp_data.car_yellow && !rsp_data.car_red && !rsp_data.walk_green, "wrong lamps in green")

endmodule

bind pedestrian_traffic_light_sequencer ptls_checker u_ptls_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

@@ bench/ptls_lamp_checker.sv @@
// Scoreboard for the pedestrian traffic light sequencer: tracks the register
// writes, predicts the lamps and phase for every accepted word, checks results.
// Depends on ptls_pkg.
module ptls_lamp_checker
   import ptls_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  req_type           req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  rsp_type           rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic              pready,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output int                mismatches,
   output int                words_due,
   output int                words_checked,
   output logic [6:0]        phases_seen
);

   logic [CFG_W-1:0]       len_green, len_red, len_walk, len_blink;
   phase_type              cur_phase;
   logic [COUNT_WIDTH-1:0] phase_count;
   logic                   latched;
   logic [5:0]             lamps;
   rsp_type                lamp_words_due[$];
   rsp_type                want;

   function void enter_phase(phase_type p);
      cur_phase = p;
      phase_count = '0;
      case (p)
         PH_GREEN: lamps = (lamps & ~(L_WG | L_WY | L_CY | L_CR)) | L_CG;
         PH_YEL_G, PH_YEL_R: lamps = (lamps & ~(L_WG | L_WY)) ^ L_CY;
         PH_RED: lamps = (lamps & ~(L_WG | L_WY | L_CG | L_CY)) | L_CR;
         PH_ALERT: lamps = ((lamps & ~(L_WG | L_WY)) | L_WR) ^ (L_CY | L_WY);
         PH_WALK: lamps = L_WG | L_CR;
         default: lamps = lamps ^ (L_CY | L_WY);
      endcase
   endfunction

   function void close_phase();
      case (cur_phase)
         PH_GREEN: begin
            if (latched) enter_phase(PH_ALERT);
            else enter_phase(PH_YEL_G);
         end
         PH_YEL_G: begin
            lamps = lamps & ~(L_CY | L_WY);
            if (latched) enter_phase(PH_ALERT);
            else enter_phase(PH_RED);
         end
         PH_YEL_R: begin
            lamps = lamps & ~(L_CY | L_WY);
            if (latched) enter_phase(PH_ALERT);
            else enter_phase(PH_GREEN);
         end
         PH_RED: begin
            if (latched) enter_phase(PH_WALK);
            else enter_phase(PH_YEL_R);
         end
         PH_ALERT: begin
            lamps = (lamps & ~(L_CY | L_WY)) | L_CR;
            enter_phase(PH_WALK);
         end
         PH_WALK: begin
            lamps = lamps & ~L_CR;
            enter_phase(PH_CLEAR);
         end
         default: begin
            lamps = (lamps & ~(L_CY | L_WY)) | L_WR;
            latched = 1'b0;
            enter_phase(PH_GREEN);
         end
      endcase
   endfunction

   function logic [CFG_W-1:0] phase_limit();
      logic [CFG_W-1:0] n;
      case (cur_phase)
         PH_GREEN: n = len_green;
         PH_RED:   n = len_red;
         PH_WALK:  n = len_walk;
         default:  n = len_blink;
      endcase
      if (n == '0) n = CFG_W'(1);
      return n;
   endfunction

   function rsp_type next_lamps(req_type w);
      rsp_type r;
      if (w.request && cur_phase != PH_WALK && cur_phase != PH_CLEAR) latched = 1'b1;
      if (w.tick) begin
         if (phase_count < CNT_MAX) phase_count = phase_count + 1'b1;
         if (phase_count >= phase_limit())
            close_phase();
         else if (cur_phase == PH_YEL_G || cur_phase == PH_YEL_R)
            lamps = lamps ^ L_CY;
         else if (cur_phase == PH_ALERT || cur_phase == PH_CLEAR)
            lamps = lamps ^ (L_CY | L_WY);
      end
      r.car_green   = |(lamps & L_CG);
      r.car_yellow  = |(lamps & L_CY);
      r.car_red     = |(lamps & L_CR);
      r.walk_green  = |(lamps & L_WG);
      r.walk_yellow = |(lamps & L_WY);
      r.walk_red    = |(lamps & L_WR);
      r.phase_code  = cur_phase;
      return r;
   endfunction

   task check_field(string name, int exp_val, int got_val);
      if (exp_val != got_val) begin
         $error("%s: expected %0d, got %0d", name, exp_val, got_val);
         mismatches++;
      end
   endtask

   task compare_word(rsp_type exp_w, rsp_type got_w);
      check_field("car_green", int'(exp_w.car_green), int'(got_w.car_green));
      check_field("car_yellow", int'(exp_w.car_yellow), int'(got_w.car_yellow));
      check_field("car_red", int'(exp_w.car_red), int'(got_w.car_red));
      check_field("walk_green", int'(exp_w.walk_green), int'(got_w.walk_green));
      check_field("walk_yellow", int'(exp_w.walk_yellow), int'(got_w.walk_yellow));
      check_field("walk_red", int'(exp_w.walk_red), int'(got_w.walk_red));
      check_field("phase_code", int'(exp_w.phase_code), int'(got_w.phase_code));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         len_green = LEN_RESET;
         len_red = LEN_RESET;
         len_walk = LEN_RESET;
         len_blink = LEN_RESET;
         cur_phase = PH_GREEN;
         phase_count = '0;
         latched = 1'b0;
         lamps = L_CG;
         lamp_words_due.delete();
         phases_seen = '0;
      end else begin
         // result first: a word accepted at this edge answers from the next cycle
         if (rsp_valid && rsp_ready) begin
            if (lamp_words_due.size() == 0) begin
               $error("result word with nothing expected");
               mismatches++;
            end else begin
               want = lamp_words_due.pop_front();
               compare_word(want, rsp_data);
               words_checked++;
            end
         end
         if (req_valid && req_ready) begin
            lamp_words_due.push_back(next_lamps(req_data));
            phases_seen[cur_phase] = 1'b1;
         end
         if (psel && penable && pwrite && pready) begin
            case (reg_idx_type'(paddr[3:2]))
               REG_GREEN: len_green = pwdata[CFG_W-1:0];
               REG_RED:   len_red = pwdata[CFG_W-1:0];
               REG_WALK:  len_walk = pwdata[CFG_W-1:0];
               REG_BLINK: len_blink = pwdata[CFG_W-1:0];
               default:   len_blink = len_blink;
            endcase
         end
      end
      words_due = lamp_words_due.size();
   end

endmodule

@@ bench/pedestrian_traffic_light_sequencer_tb.sv @@
// Testbench top for the pedestrian traffic light sequencer: clock, reset,
// register writes, tick/request words with random stalls, and the verdict.
// Depends on ptls_pkg, ptls_lamp_checker and the sequencer RTL.
module pedestrian_traffic_light_sequencer_tb;
   import ptls_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   // {tick, request} words, sent with phase lengths of one or two ticks
   localparam logic [1:0] opening_words [25] = '{
      2'b00, 2'b01, 2'b10, 2'b10, 2'b11, 2'b10, 2'b01, 2'b10, 2'b10,
      2'b10, 2'b10, 2'b01, 2'b10, 2'b10, 2'b10, 2'b10, 2'b11, 2'b10,
      2'b10, 2'b10, 2'b10, 2'b10, 2'b10, 2'b10, 2'b11
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_data;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0] pwdata = '0;
   logic [DATA_W-1:0] prdata;
   logic              pready;
   int                mismatches;
   int                words_due;
   int                words_checked;
   logic [6:0]        phases_seen;
   int                send_idle = 0;
   int                recv_idle = 0;
   int                cycle_count = 0;
   int                words_sent = 0;

   pedestrian_traffic_light_sequencer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   ptls_lamp_checker i_checker (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   // all tasks start and end at a falling edge
   task send_word(req_type w);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
      @(negedge clock);
   endtask

   task random_words(int count, int tick_pct, int req_pct);
      req_type w;
      for (int i = 0; i < count; i++) begin
         w.tick = ($urandom_range(99) < tick_pct);
         w.request = ($urandom_range(99) < req_pct);
         send_word(w);
      end
   endtask

   task drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (words_due != 0) @(negedge clock);
   endtask

   task settle();
      drain();
      repeat (3) @(negedge clock);
   endtask

   task write_reg(reg_idx_type idx, logic [DATA_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ADDR_W'(idx) << 2;
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
   endtask

   task configure(logic [DATA_W-1:0] g, logic [DATA_W-1:0] r,
                  logic [DATA_W-1:0] w, logic [DATA_W-1:0] b);
      settle();
      write_reg(REG_GREEN, g);
      write_reg(REG_RED, r);
      write_reg(REG_WALK, w);
      write_reg(REG_BLINK, b);
      @(negedge clock);
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("pedestrian_traffic_light_sequencer_tb: done, errors");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      send_idle = 10;
      recv_idle = 54;
      random_words(200, 70, 8);
      // zero length, upper bits ignored
      configure(32'd0, 32'h0000_0302, 32'd1, 32'hFFFF_FF01);
      foreach (opening_words[i]) send_word(req_type'(opening_words[i]));
      random_words(200, 80, 10);
      configure(32'd255, 32'd255, 32'd255, 32'd255);
      random_words(300, 95, 4);
      send_idle = 54;
      recv_idle = 10;
      configure(32'd3, 32'd4, 32'd5, 32'd2);
      random_words(150, 60, 12);
      drain();
      random_words(150, 60, 12);
      configure(32'd1, 32'd1, 32'd1, 32'd1);
      random_words(200, 50, 20);
      send_idle = 0;
      recv_idle = 0;
      configure(32'd7, 32'd2, 32'd3, 32'd5);
      random_words(200, 75, 6);
      settle();
      $display("covered %0d words over %0d cycles, %0d results checked",
               words_sent, cycle_count, words_checked);
      $display("phase codes reached (one bit each, code 0 rightmost): %b", phases_seen);
      if (mismatches == 0)
         $display("pedestrian_traffic_light_sequencer_tb: done, clean");
      else
         $display("pedestrian_traffic_light_sequencer_tb: done, errors");
      $finish;
   end

endmodule
